@@ sv/wsr_pkg.sv @@
// Shared types and constants for the windowed spike-rate unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wsr_pkg;

  // Fixed field widths of the ports
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 16;
  localparam int CFG_W    = 7;
  localparam int SUM_W    = 29;

  // Width for start + length bounds checks (covers every legal train depth)
  localparam int CHK_W = 18;

  // Action codes, also used as command kinds between front and back
  localparam logic [ACTION_W-1:0] ACT_COEF   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  // Q1.15 one, the largest coefficient stored
  localparam logic [VALUE_W-1:0] COEF_ONE = 16'h8000;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 7'd64;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Defaults of the top-level parameters
  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_TRAIN_DEPTH  = 4096;
  localparam int DEF_SAMPLE_BITS  = 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Decoded command handed from front to back
  typedef struct packed {
    logic [ACTION_W-1:0] kind;
    logic [INDEX_W-1:0]  addr;
    logic [VALUE_W-1:0]  data;
    logic [CFG_W-1:0]    len;
    logic                flag;
  } cmd_t;

endpackage

@@ sv/windowed_spike_rate_unit.sv @@
// Top level of the windowed spike-rate unit: front end, command queue, back end.
// Depends on wsr_pkg, wsr_front, wsr_queue, wsr_back.
`timescale 1ns / 1ps

// Input channel (in_valid/in_stall) carries action, index, value: coefficient
// writes, sample writes and rate queries. Output channel (out_valid/out_stall)
// carries one rate_sum/out_of_range result per query, none for writes.
// window_length is written through cfg_valid/cfg_ready; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// Writes retire one per cycle unless a query holds the back end or the queue
// head, passing through the front holding register and the command queue. A
// query that runs for len taps (len = min(window_length, WINDOW_DEPTH)) holds
// the back end while it issues one tap per cycle through the single sample
// and coefficient read port, a multiply stage and an accumulate stage; a
// flagged or empty query issues no taps. The next query pops in the cycle
// after the result transfer: no query starts before the last result has left.
// A four-entry command queue and a front holding register keep accepting
// while a result waits; when out_stall holds, the result register keeps its
// data and queries back up into the queue, then in_stall rises.
// Reset (rst, synchronous) empties front, queue and pipeline and sets
// window_length to 64; memory contents are undefined until written.
module windowed_spike_rate_unit #(
  parameter int WINDOW_DEPTH = wsr_pkg::DEF_WINDOW_DEPTH,
  parameter int TRAIN_DEPTH  = wsr_pkg::DEF_TRAIN_DEPTH,
  parameter int SAMPLE_BITS  = wsr_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wsr_pkg::ACTION_W-1:0] action,
  input  logic [wsr_pkg::INDEX_W-1:0]  index,
  input  logic [wsr_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wsr_pkg::SUM_W-1:0]    rate_sum,
  output logic                         out_of_range,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wsr_pkg::CFG_W-1:0]    window_length
);
  import wsr_pkg::*;

  logic fr_valid;
  cmd_t fr_cmd;
  logic q_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic busy;

  wsr_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TRAIN_DEPTH  (TRAIN_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .index         (index),
    .value         (value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .window_length (window_length),
    .cmd_valid     (fr_valid),
    .cmd           (fr_cmd),
    .cmd_ready     (q_ready)
  );

  wsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fr_valid),
    .push_cmd (fr_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .head     (q_cmd),
    .pop      (q_pop)
  );

  wsr_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TRAIN_DEPTH  (TRAIN_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate_sum     (rate_sum),
    .out_of_range (out_of_range)
  );

  // A flagged result always carries a zero sum
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> rate_sum == '0)
    else $error("flagged result with nonzero sum");

  // The back end only pops a queue entry that exists
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

  // While a window is accumulating the result register stays empty
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    busy |-> !out_valid)
    else $error("result pending during accumulation");

  // No result survives a reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

@@ sv/wsr_front.sv @@
// Front end: input transfer, window_length register, command decode.
// Depends on wsr_pkg.
`timescale 1ns / 1ps

module wsr_front #(
  parameter int WINDOW_DEPTH = wsr_pkg::DEF_WINDOW_DEPTH,
  parameter int TRAIN_DEPTH  = wsr_pkg::DEF_TRAIN_DEPTH,
  parameter int SAMPLE_BITS  = wsr_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wsr_pkg::ACTION_W-1:0] action,
  input  logic [wsr_pkg::INDEX_W-1:0]  index,
  input  logic [wsr_pkg::VALUE_W-1:0]  value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wsr_pkg::CFG_W-1:0]    window_length,
  output logic                         cmd_valid,
  output wsr_pkg::cmd_t                cmd,
  input  logic                         cmd_ready
);
  import wsr_pkg::*;

  logic [CFG_W-1:0] wlen;
  logic [CFG_W-1:0] eff_len;
  logic             accept;
  logic             keep;
  logic             advance;
  cmd_t             dec;

  // Config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= WINDOW_LENGTH_RESET;
    end else if (cfg_valid) begin
      wlen <= window_length;
    end
  end

  // Length clipped to the coefficient store
  assign eff_len = (CHK_W'(wlen) > CHK_W'(WINDOW_DEPTH)) ? CFG_W'(WINDOW_DEPTH) : wlen;

  // Decode and classify; writes outside a store and the unused action are dropped
  always_comb begin
    dec.kind = action;
    dec.addr = index;
    dec.len  = eff_len;
    dec.flag = (CHK_W'(index) + CHK_W'(eff_len)) > CHK_W'(TRAIN_DEPTH);
    dec.data = value;
    keep     = 1'b0;
    case (action)
      ACT_COEF: begin
        dec.data = (value > COEF_ONE) ? COEF_ONE : value;
        keep     = CHK_W'(index) < CHK_W'(WINDOW_DEPTH);
      end
      ACT_SAMPLE: begin
        dec.data = VALUE_W'(value[SAMPLE_BITS-1:0]);
        keep     = CHK_W'(index) < CHK_W'(TRAIN_DEPTH);
      end
      ACT_QUERY: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // One-entry holding register toward the queue
  assign in_stall = cmd_valid && !cmd_ready;
  assign accept   = in_valid && !in_stall;
  assign advance  = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      cmd <= dec;
    end
  end

endmodule

@@ sv/wsr_queue.sv @@
// Short command queue that decouples the front end from the MAC back end.
// Depends on wsr_pkg.
`timescale 1ns / 1ps

module wsr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wsr_pkg::cmd_t push_cmd,
  output logic          ready,
  output logic          valid,
  output wsr_pkg::cmd_t head,
  input  logic          pop
);
  import wsr_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign ready   = count < (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/wsr_back.sv @@
// Back end: coefficient and sample memories, MAC sequencer, result register.
// Depends on wsr_pkg.
`timescale 1ns / 1ps

module wsr_back #(
  parameter int WINDOW_DEPTH = wsr_pkg::DEF_WINDOW_DEPTH,
  parameter int TRAIN_DEPTH  = wsr_pkg::DEF_TRAIN_DEPTH,
  parameter int SAMPLE_BITS  = wsr_pkg::DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  wsr_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [wsr_pkg::SUM_W-1:0]  rate_sum,
  output logic                       out_of_range
);
  import wsr_pkg::*;

  localparam int COEF_AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SAMPLE_AW = $clog2(TRAIN_DEPTH);
  localparam int PROD_W    = SAMPLE_BITS + VALUE_W;
  localparam int ACC_W     = PROD_W + CFG_W;
  localparam int SAT_W     = (ACC_W > SUM_W) ? ACC_W : SUM_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [VALUE_W-1:0]     coef_mem   [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] sample_mem [TRAIN_DEPTH];

  logic                   state;
  logic [CFG_W-1:0]       tap;
  logic [CFG_W-1:0]       len;
  logic [INDEX_W-1:0]     start;
  logic [VALUE_W-1:0]     coef_rd;
  logic [SAMPLE_BITS-1:0] sample_rd;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;
  logic                   rd_v;
  logic                   mul_v;
  logic                   issue;
  logic                   finish;
  logic                   start_query;
  logic                   we_coef;
  logic                   we_sample;
  logic [COEF_AW-1:0]     coef_raddr;
  logic [SAMPLE_AW-1:0]   sample_raddr;
  logic [SAT_W-1:0]       acc_ext;
  logic [SUM_W-1:0]       sum_sat;

  // Queue handshake: a query waits for an empty result register
  assign q_pop = q_valid && (state == ST_IDLE) &&
                 ((q_cmd.kind != ACT_QUERY) || !out_valid);
  assign start_query = q_pop && (q_cmd.kind == ACT_QUERY);
  assign we_coef     = q_pop && (q_cmd.kind == ACT_COEF);
  assign we_sample   = q_pop && (q_cmd.kind == ACT_SAMPLE);

  // Tap issue and end of window
  assign issue  = (state == ST_RUN) && (tap < len);
  assign finish = (state == ST_RUN) && !issue && !rd_v && !mul_v;
  assign busy   = state == ST_RUN;

  assign coef_raddr   = COEF_AW'(tap);
  assign sample_raddr = SAMPLE_AW'(CHK_W'(start) + CHK_W'(tap));

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (we_coef) begin
      coef_mem[COEF_AW'(q_cmd.addr)] <= q_cmd.data;
    end
    coef_rd <= coef_mem[coef_raddr];
  end

  // Sample memory
  always_ff @(posedge clk) begin
    if (we_sample) begin
      sample_mem[SAMPLE_AW'(q_cmd.addr)] <= q_cmd.data[SAMPLE_BITS-1:0];
    end
    sample_rd <= sample_mem[sample_raddr];
  end

  // Final saturation to the result width
  assign acc_ext = SAT_W'(acc);
  assign sum_sat = (acc_ext > SAT_W'(SUM_MAX)) ? SUM_MAX : acc_ext[SUM_W-1:0];

  // Sequencer control and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start_query) begin
            if (q_cmd.flag || (q_cmd.len == '0)) out_valid <= 1'b1;
            else                                  state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (finish) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: tap counter, multiply stage, accumulator, result payload
  always_ff @(posedge clk) begin
    prod <= PROD_W'(sample_rd) * PROD_W'(coef_rd);
    if (issue) tap <= tap + 1'b1;
    if (mul_v) acc <= acc + ACC_W'(prod);
    if (start_query) begin
      start        <= q_cmd.addr;
      len          <= q_cmd.len;
      tap          <= '0;
      acc          <= '0;
      rate_sum     <= '0;
      out_of_range <= q_cmd.flag;
    end
    if (finish) begin
      rate_sum     <= sum_sat;
      out_of_range <= 1'b0;
    end
  end

endmodule
